@@ design/lsg_pkg.sv @@
// ----------------------------------------------------------------------------
// lsg_pkg
// Shared types and constants for the log-sigmoid forward/backward unit:
// fixed-point formats, opcode, queue entry and the exp tap table.
// ----------------------------------------------------------------------------
package lsg_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int Q_BITS     = 30;
  localparam int P_W        = Q_BITS + 1;
  localparam int Y_W        = Q_BITS + 2;
  localparam int T_W        = DATA_WIDTH + Q_BITS + 1 - FRAC_BITS;

  localparam logic [Q_BITS:0]   LOG2E_Q30 = 31'd1549082005;
  localparam logic [Q_BITS-1:0] LN2_Q30   = 30'd744261118;
  localparam logic [Q_BITS:0]   ONE_Q     = P_W'(1) << Q_BITS;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_BWD = 1'b1
  } lsg_op_t;

  typedef struct packed {
    lsg_op_t               op;
    logic                  x_neg;
    logic [DATA_WIDTH-1:0] x_val;
    logic                  g_neg;
    logic [DATA_WIDTH-1:0] g_mag;
  } lsg_tag_t;

  typedef struct packed {
    lsg_tag_t       tag;
    logic [T_W-1:0] t;
  } lsg_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lsg_qstat_t;

  // 2^(-2^-k) in Q30 by repeated integer square roots
  function automatic logic [Q_BITS-1:0] exp_tap(input int k);
    logic [63:0] tk;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int s;
    int i;
    tk = 64'd1 << (Q_BITS - 1);
    for (s = 1; s <= k; s++) begin
      v = tk << Q_BITS;
      r = '0;
      b = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
        if (b > v) b = b >> 2;
      end
      for (i = 0; i < 32; i++) begin
        if (b != '0) begin
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
      end
      tk = r;
    end
    return tk[Q_BITS-1:0];
  endfunction

endpackage

@@ design/lsg_queue.sv @@
// ----------------------------------------------------------------------------
// lsg_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsg_queue
  import lsg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lsg_item_t  push_item,
  input  logic       pop,
  output lsg_item_t  head_item,
  output lsg_qstat_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsg_item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  always_comb begin
    q_stat.full  = (cnt_r == CNT_W'(DEPTH));
    q_stat.empty = (cnt_r == '0);
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    head_item    = slot_r[rd_ptr_r];
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/lsg_front.sv @@
// ----------------------------------------------------------------------------
// lsg_front
// Takes requests, splits sign and magnitude and scales |x| by log2(e).
// ----------------------------------------------------------------------------
module lsg_front
  import lsg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic signed [DATA_WIDTH-1:0] in_grad_in,
  input  lsg_qstat_t                   q_stat,
  output logic                         push,
  output lsg_item_t                    push_item
);

  localparam int PROD_W = DATA_WIDTH + Q_BITS + 1;

  logic                  f_vld_r, f_vld_nxt;
  lsg_item_t             f_item_r, f_item_nxt;
  logic                  accept;
  logic                  x_neg, g_neg;
  logic [DATA_WIDTH-1:0] x_mag, g_mag;
  logic [PROD_W-1:0]     t_prod;

  assign in_stall  = f_vld_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_vld_r && !q_stat.full;
  assign push_item = f_item_r;

  always_comb begin
    x_neg  = in_x_value[DATA_WIDTH-1];
    g_neg  = in_grad_in[DATA_WIDTH-1];
    x_mag  = x_neg ? DATA_WIDTH'(~in_x_value + 1'b1) : in_x_value;
    g_mag  = g_neg ? DATA_WIDTH'(~in_grad_in + 1'b1) : in_grad_in;
    t_prod = PROD_W'(x_mag) * PROD_W'(LOG2E_Q30);
    f_item_nxt.tag.op    = lsg_op_t'(in_opcode);
    f_item_nxt.tag.x_neg = x_neg;
    f_item_nxt.tag.x_val = in_x_value;
    f_item_nxt.tag.g_neg = g_neg;
    f_item_nxt.tag.g_mag = g_mag;
    f_item_nxt.t         = t_prod[PROD_W-1:FRAC_BITS];
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end else begin
      f_vld_nxt = f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

@@ design/lsg_back.sv @@
// ----------------------------------------------------------------------------
// lsg_back
// Execution pipeline: exp(-|x|) product chain, shared divide and log2
// squaring chain, final multiply, rounding, saturation and output register.
// ----------------------------------------------------------------------------
module lsg_back
  import lsg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  lsg_qstat_t                   q_stat,
  input  lsg_item_t                    head_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_value
);

  localparam int E_N   = Q_BITS + 1;
  localparam int D_N   = Q_BITS + 2;
  localparam int N_W   = T_W - Q_BITS;
  localparam int GS_W  = DATA_WIDTH + P_W;
  localparam int R_W   = DATA_WIDTH + 2;
  localparam logic [P_W-1:0]  LN_RND = P_W'(1) << (Q_BITS - 1 - FRAC_BITS);
  localparam logic [GS_W-1:0] GS_RND = GS_W'(1) << (Q_BITS - 1);
  localparam logic signed [R_W-1:0] SAT_HI =
    {{(R_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [R_W-1:0] SAT_LO =
    {{(R_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

  logic adv;

  logic [E_N-1:0]    e_vld_r;
  lsg_tag_t          e_tag_r [E_N];
  logic [P_W-1:0]    e_p_r   [E_N];
  logic [T_W-1:0]    e_t_r   [E_N];

  logic [D_N-1:0]    d_vld_r;
  lsg_tag_t          d_tag_r   [D_N];
  logic [Y_W-1:0]    d_y_r     [D_N];
  logic              d_lflag_r [D_N];
  logic [P_W-1:0]    d_ly_r    [D_N];
  logic [Q_BITS-1:0] d_lacc_r  [D_N];
  logic [Y_W-1:0]    d_rem_r   [D_N];
  logic [P_W-1:0]    d_q_r     [D_N];
  logic              d0_n0_r;

  logic [N_W-1:0]    z_n;
  logic [P_W-1:0]    z_val;
  logic [Y_W-1:0]    y_sum;
  logic [P_W-1:0]    num;

  logic                    m_vld_r;
  lsg_tag_t                m_tag_r;
  logic [P_W-1:0]          m_ln_r;
  logic [GS_W-1:0]         m_gs_r;
  logic [P_W-1:0]          l_val;
  logic [P_W+Q_BITS-1:0]   ln_prod;
  logic [GS_W-1:0]         gs_prod;

  logic [P_W-1:0]          ln_sum, lnq;
  logic [GS_W-1:0]         gs_sum;
  logic [DATA_WIDTH:0]     mag;
  logic signed [R_W-1:0]   m_sx, r_fwd, r_bwd, r_full, r_sat;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_res_r, out_res_nxt;

  assign adv              = !out_valid_r || !out_stall;
  assign pop              = adv && !q_stat.empty;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= '0;
      d_vld_r <= '0;
      m_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= {e_vld_r[E_N-2:0], !q_stat.empty};
      d_vld_r <= {d_vld_r[D_N-2:0], e_vld_r[E_N-1]};
      m_vld_r <= d_vld_r[D_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tag_r[0] <= head_item.tag;
      e_t_r[0]   <= head_item.t;
      e_p_r[0]   <= ONE_Q;
    end
  end

  for (genvar k = 1; k < E_N; k++) begin : g_exp
    localparam logic [Q_BITS-1:0] TAP = exp_tap(k);
    logic [P_W+Q_BITS-1:0] prod;
    logic [P_W-1:0]        p_nxt;
    assign prod  = (P_W + Q_BITS)'(e_p_r[k-1]) * (P_W + Q_BITS)'(TAP);
    assign p_nxt = e_t_r[k-1][Q_BITS-k] ? prod[P_W+Q_BITS-1:Q_BITS] : e_p_r[k-1];
    always_ff @(posedge clk) begin
      if (adv) begin
        e_tag_r[k] <= e_tag_r[k-1];
        e_t_r[k]   <= e_t_r[k-1];
        e_p_r[k]   <= p_nxt;
      end
    end
  end

  always_comb begin
    z_n   = e_t_r[E_N-1][T_W-1:Q_BITS];
    z_val = e_p_r[E_N-1] >> z_n;
    y_sum = Y_W'(ONE_Q) + Y_W'(z_val);
    num   = e_tag_r[E_N-1].x_neg ? ONE_Q : z_val;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tag_r[0]   <= e_tag_r[E_N-1];
      d_y_r[0]     <= y_sum;
      d_lflag_r[0] <= y_sum[Y_W-1];
      d_ly_r[0]    <= y_sum[P_W-1:0];
      d_lacc_r[0]  <= '0;
      d_rem_r[0]   <= Y_W'(num >> 1);
      d_q_r[0]     <= '0;
      d0_n0_r      <= num[0];
    end
  end

  for (genvar j = 0; j < D_N - 1; j++) begin : g_div
    logic              dbit;
    logic [Y_W:0]      rr;
    logic              ge;
    logic [Y_W-1:0]    rem_nxt;
    logic [P_W-1:0]    q_nxt;
    logic [P_W-1:0]    ly_nxt;
    logic [Q_BITS-1:0] lacc_nxt;

    if (j == 0) begin : g_first
      assign dbit = d0_n0_r;
    end else begin : g_rest
      assign dbit = 1'b0;
    end

    assign rr      = {d_rem_r[j], dbit};
    assign ge      = (rr >= {1'b0, d_y_r[j]});
    assign rem_nxt = ge ? Y_W'(rr - {1'b0, d_y_r[j]}) : rr[Y_W-1:0];
    assign q_nxt   = {d_q_r[j][P_W-2:0], ge};

    if (j < Q_BITS) begin : g_sq
      logic [2*P_W-1:0] sq;
      logic [Y_W-1:0]   s2;
      assign sq       = (2 * P_W)'(d_ly_r[j]) * (2 * P_W)'(d_ly_r[j]);
      assign s2       = sq[2*P_W-1:Q_BITS];
      assign ly_nxt   = s2[Y_W-1] ? s2[Y_W-1:1] : s2[P_W-1:0];
      assign lacc_nxt = {d_lacc_r[j][Q_BITS-2:0], s2[Y_W-1]};
    end else begin : g_hold
      assign ly_nxt   = d_ly_r[j];
      assign lacc_nxt = d_lacc_r[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_tag_r[j+1]   <= d_tag_r[j];
        d_y_r[j+1]     <= d_y_r[j];
        d_lflag_r[j+1] <= d_lflag_r[j];
        d_ly_r[j+1]    <= ly_nxt;
        d_lacc_r[j+1]  <= lacc_nxt;
        d_rem_r[j+1]   <= rem_nxt;
        d_q_r[j+1]     <= q_nxt;
      end
    end
  end

  always_comb begin
    l_val   = d_lflag_r[D_N-1] ? ONE_Q : P_W'(d_lacc_r[D_N-1]);
    ln_prod = (P_W + Q_BITS)'(l_val) * (P_W + Q_BITS)'(LN2_Q30);
    gs_prod = GS_W'(d_tag_r[D_N-1].g_mag) * GS_W'(d_q_r[D_N-1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag_r <= d_tag_r[D_N-1];
      m_ln_r  <= ln_prod[P_W+Q_BITS-1:Q_BITS];
      m_gs_r  <= gs_prod;
    end
  end

  always_comb begin
    ln_sum = m_ln_r + LN_RND;
    lnq    = ln_sum >> (Q_BITS - FRAC_BITS);
    m_sx   = m_tag_r.x_neg ? R_W'($signed(m_tag_r.x_val)) : '0;
    r_fwd  = m_sx - $signed(R_W'(lnq));
    gs_sum = m_gs_r + GS_RND;
    mag    = gs_sum[GS_W-1:Q_BITS];
    r_bwd  = m_tag_r.g_neg ? -$signed(R_W'(mag)) : $signed(R_W'(mag));
    case (m_tag_r.op)
      OP_FWD:  r_full = r_fwd;
      default: r_full = r_bwd;
    endcase
    if (r_full > SAT_HI) begin
      r_sat = SAT_HI;
    end else if (r_full < SAT_LO) begin
      r_sat = SAT_LO;
    end else begin
      r_sat = r_full;
    end
    out_res_nxt   = r_sat[DATA_WIDTH-1:0];
    out_valid_nxt = adv ? m_vld_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

@@ design/log_sigmoid_fwd_bwd_unit_top.sv @@
// ----------------------------------------------------------------------------
// log_sigmoid_fwd_bwd_unit_top
// Log-sigmoid forward value and backward gradient in signed Q4.12.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    in_opcode, in_x_value, in_grad_in
// out      out  out_valid / out_stall  out_result_value
//
// One request per clock sustained while out_stall is low; each request runs
// through the 30-stage exp product chain and the 31-stage shared divide /
// log2 squaring chain.
// rst_n low at a clock edge empties the front register, queue and pipeline.
// out_stall freezes the back pipeline while out_valid is high; in_stall
// rises once the queue and the front register are both full.
// ----------------------------------------------------------------------------
module log_sigmoid_fwd_bwd_unit_top
  import lsg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic signed [DATA_WIDTH-1:0] in_grad_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_value
);

  lsg_qstat_t q_stat;
  lsg_item_t  push_item;
  lsg_item_t  head_item;
  logic       push;
  logic       pop;

  lsg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_x_value (in_x_value),
    .in_grad_in (in_grad_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  lsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  lsg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value)
  );

endmodule

@@ design/lsg_checker.sv @@
// ----------------------------------------------------------------------------
// lsg_checker
// Port-level checks on reset, input backpressure release and output hold.
// ----------------------------------------------------------------------------
module lsg_checker
  import lsg_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] out_result_value
);

  a_reset_quiet: assert property (
    @(posedge clk) !rst_n |=> !out_valid && !in_stall
  ) else $error("outputs not quiet after reset");

  a_stall_release: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall && !(out_valid && out_stall) |=> !in_stall
  ) else $error("input stall held while the back pipeline drains");

  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
  ) else $error("stalled result dropped or changed");

endmodule

bind log_sigmoid_fwd_bwd_unit_top lsg_checker u_lsg_checker (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for log_sigmoid_fwd_bwd_unit_top. It drives forward and backward
// requests through the valid/stall input channel and checks every result
// against a fixed-point log-sigmoid predictor (Q30 exp, log2 and divide) in
// request order. It covers directed extremes, a long output hold that backs
// up the input, and a random mix with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;
  localparam longint unsigned UNITY = 64'd1 << Q_BITS;

  typedef struct {
    lsg_op_t                      op;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] g;
    logic signed [DATA_WIDTH-1:0] value;
  } pending_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_opcode = 1'b0;
  logic signed [DATA_WIDTH-1:0] in_x_value = '0;
  logic signed [DATA_WIDTH-1:0] in_grad_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_result_value;

  pending_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  hold_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  log_sigmoid_fwd_bwd_unit_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_x_value       (in_x_value),
    .in_grad_in       (in_grad_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    int b;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // exp(-a) in Q30 for a magnitude a in Q(FRAC_BITS)
  function automatic longint unsigned exp_neg_q30(input longint unsigned a);
    longint unsigned t;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned prod;
    longint unsigned tap;
    int k;
    t = (a * LOG2E_Q30) >> FRAC_BITS;
    whole = t >> Q_BITS;
    frac = t & (UNITY - 1);
    prod = UNITY;
    tap = UNITY >> 1;
    for (k = 1; k <= Q_BITS; k++) begin
      tap = int_sqrt(tap << Q_BITS);
      if ((frac >> (Q_BITS - k)) & 64'd1) prod = (prod * tap) >> Q_BITS;
    end
    if (whole >= 31) return 0;
    return prod >> whole;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] logsig_result(
    input lsg_op_t op, input logic signed [DATA_WIDTH-1:0] x,
    input logic signed [DATA_WIDTH-1:0] g);
    longint          sx;
    longint          sg;
    longint unsigned z;
    longint unsigned y;
    longint unsigned sq;
    longint unsigned l2;
    longint unsigned ln;
    longint unsigned ratio;
    longint unsigned mag;
    longint          r;
    longint          hi;
    int i;
    sx = x;
    sg = g;
    z = exp_neg_q30(longint'(sx < 0 ? -sx : sx));
    y = UNITY + z;
    if (op == OP_FWD) begin
      l2 = 0;
      if (y >= 2 * UNITY) begin
        l2 = UNITY;
      end else begin
        sq = y;
        for (i = 1; i <= Q_BITS; i++) begin
          sq = (sq * sq) >> Q_BITS;
          if (sq >= 2 * UNITY) begin
            sq = sq >> 1;
            l2 = l2 | (64'd1 << (Q_BITS - i));
          end
        end
      end
      ln = (l2 * LN2_Q30) >> Q_BITS;
      ln = (ln + (64'd1 << (Q_BITS - 1 - FRAC_BITS))) >> (Q_BITS - FRAC_BITS);
      r = (sx < 0 ? sx : 0) - longint'(ln);
    end else begin
      ratio = (sx < 0) ? ((UNITY << Q_BITS) / y) : ((z << Q_BITS) / y);
      mag = (longint'(sg < 0 ? -sg : sg) * ratio + (UNITY >> 1)) >> Q_BITS;
      r = (sg < 0) ? -longint'(mag) : longint'(mag);
    end
    hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return DATA_WIDTH'(r);
  endfunction

  task automatic send_request(input lsg_op_t op, input logic signed [DATA_WIDTH-1:0] x,
                              input logic signed [DATA_WIDTH-1:0] g);
    int gap;
    pending_result_t item;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_x_value <= x;
    in_grad_in <= g;
    do @(posedge clk); while (in_stall);
    item.op = op;
    item.x = x;
    item.g = g;
    item.value = logsig_result(op, x, g);
    pending_results.push_back(item);
  endtask

  task automatic test_directed();
    logic signed [DATA_WIDTH-1:0] g;
    g = DATA_WIDTH'($urandom);
    send_request(OP_FWD, 16'sd0, g);
    send_request(OP_FWD, 16'sd1, ~g);
    send_request(OP_FWD, -16'sd1, 16'sh7fff);
    send_request(OP_FWD, 16'sh7fff, 16'sh8000);
    send_request(OP_FWD, 16'sh8000, 16'sd0);
    send_request(OP_FWD, 16'sh8001, 16'sd0);
    send_request(OP_FWD, 16'sd4096, g);
    send_request(OP_FWD, -16'sd4096, g);
    send_request(OP_BWD, 16'sd0, 16'sh7fff);
    send_request(OP_BWD, 16'sd0, 16'sh8000);
    send_request(OP_BWD, 16'sd0, 16'sd1);
    send_request(OP_BWD, 16'sd0, -16'sd1);
    send_request(OP_BWD, 16'sd0, 16'sd3);
    send_request(OP_BWD, 16'sh7fff, 16'sh7fff);
    send_request(OP_BWD, 16'sh7fff, 16'sh8000);
    send_request(OP_BWD, 16'sh8000, 16'sh8000);
    send_request(OP_BWD, 16'sh8000, 16'sh7fff);
    send_request(OP_BWD, -16'sd1, 16'sh8000);
    send_request(OP_BWD, 16'sd1, 16'sh7fff);
    send_request(OP_BWD, 16'sd2048, 16'sd0);
    send_request(OP_BWD, -16'sd12288, 16'sh5555);
    send_request(OP_BWD, 16'sd12288, 16'shaaaa);
  endtask

  task automatic test_output_hold();
    int i;
    tx_idle_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (i = 0; i < HOLD_ITEMS; i++) begin
      send_request(lsg_op_t'($urandom_range(0, 1)), DATA_WIDTH'($urandom),
                   DATA_WIDTH'($urandom));
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_mix(input int count);
    int i;
    lsg_op_t op;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] g;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      op = lsg_op_t'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0, 1: x = DATA_WIDTH'($urandom);
        2: x = DATA_WIDTH'(int'($urandom_range(0, 24576)) - 12288);
        default: x = DATA_WIDTH'(int'($urandom_range(0, 64)) - 32);
      endcase
      case ($urandom_range(0, 7))
        0: g = 16'sh7fff;
        1: g = 16'sh8000;
        2: g = DATA_WIDTH'(int'($urandom_range(0, 8)) - 4);
        default: g = DATA_WIDTH'($urandom);
      endcase
      send_request(op, x, g);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // check each accepted result, then decide the stall for the next cycle
  always @(posedge clk) begin
    pending_result_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result %0d", out_result_value);
      end else begin
        exp_item = pending_results.pop_front();
        if (out_result_value !== exp_item.value) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch op=%s x=%0d g=%0d: expected %0d, got %0d",
                     exp_item.op.name(), exp_item.x, exp_item.g,
                     exp_item.value, out_result_value);
        end
      end
      stall_left = rx_idle_on ? $urandom_range(0, 8) : 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_hold();
    test_random_mix(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
